FILE: hdl/dse_pkg.sv
// ----------------------------------------------------------------------------
// dse_pkg: shared types and constants for the distinct subset enumerator
// Payload structs, mode and status codes, controller states and commands.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int VALUE_WIDTH_DEF  = 32;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ACK   = 2'd3;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic        [3:0]  position_in_subset;
    logic        [4:0]  subset_size;
    logic        [16:0] subset_number;
    logic               last_of_run;
    logic        [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT_RD, S_SORT_CMP, S_PUSH, S_POP, S_SCAN_RD, S_SCAN_CMP,
    S_EMIT_RD, S_EMIT, S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;        // reset all enumeration state
    logic load;         // store input value
    logic restart;      // restart enumeration
    logic sort_init;    // start insertion sort
    logic sort_rd;      // read pair j-1,j
    logic sort_step;    // swap or advance
    logic push_start;   // push start index
    logic pop;          // pop top, set scan index
    logic scan_rd;      // read i and j
    logic scan_step;    // compare, push or advance
    logic emit_init;    // p = 0
    logic emit_rd;      // read element p
    logic emit_out;     // load output register with element
    logic resp;         // load output register with single response
    logic [1:0] resp_status;
    logic set_exhaust;
    logic set_sorted;
    logic count_inc;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic sorted;
    logic exhausted;
    logic sort_done;    // outer index reached n
    logic can_push;     // start < n and depth < max
    logic depth_zero;
    logic scan_end;     // j reached n
    logic scan_hit;     // values differ
    logic emit_last;    // p+1 == depth
    logic out_busy;     // output register full, not taken
  } stat_t;

endpackage

FILE: hdl/dse_ctrl.sv
// ----------------------------------------------------------------------------
// dse_ctrl: controller of the distinct subset enumerator
// Sequences sort, stack advance and element emission.
// ----------------------------------------------------------------------------
module dse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  input  dse_pkg::stat_t    stat,
  output dse_pkg::cmd_t     cmd
);

  dse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dse_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == dse_pkg::S_IDLE) && !stat.out_busy;

  always_comb begin
    state_next = state;
    case (state)
      dse_pkg::S_IDLE: begin
        if (in_valid && in_ready && in_mode == dse_pkg::MODE_NEXT) begin
          if (!stat.sorted)         state_next = dse_pkg::S_SORT_RD;
          else if (stat.exhausted)  state_next = dse_pkg::S_RESP;
          else if (stat.can_push)   state_next = dse_pkg::S_PUSH;
          else                      state_next = dse_pkg::S_POP;
        end
      end
      dse_pkg::S_SORT_RD:  state_next = stat.sort_done ? dse_pkg::S_RESP : dse_pkg::S_SORT_CMP;
      dse_pkg::S_SORT_CMP: state_next = dse_pkg::S_SORT_RD;
      dse_pkg::S_PUSH:     state_next = dse_pkg::S_EMIT_RD;
      dse_pkg::S_POP:      state_next = stat.depth_zero ? dse_pkg::S_RESP : dse_pkg::S_SCAN_RD;
      dse_pkg::S_SCAN_RD:  state_next = stat.scan_end ? dse_pkg::S_POP : dse_pkg::S_SCAN_CMP;
      dse_pkg::S_SCAN_CMP: state_next = stat.scan_hit ? dse_pkg::S_EMIT_RD : dse_pkg::S_SCAN_RD;
      dse_pkg::S_EMIT_RD:  if (!stat.out_busy) state_next = dse_pkg::S_EMIT;
      dse_pkg::S_EMIT:     state_next = stat.emit_last ? dse_pkg::S_IDLE : dse_pkg::S_EMIT_RD;
      dse_pkg::S_RESP:     if (!stat.out_busy) state_next = dse_pkg::S_IDLE;
      default:             state_next = dse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      dse_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_mode)
            dse_pkg::MODE_LOAD: begin
              cmd.resp = 1'b1;
              if (stat.full) cmd.resp_status = dse_pkg::ST_FULL;
              else begin
                cmd.resp_status = dse_pkg::ST_ACK;
                cmd.load        = 1'b1;
                cmd.restart     = 1'b1;
              end
            end
            dse_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            dse_pkg::MODE_NEXT: begin
              if (!stat.sorted) cmd.sort_init = 1'b1;
              else if (!stat.exhausted && stat.can_push) cmd.push_start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      dse_pkg::S_SORT_RD:  cmd.sort_rd = 1'b1;
      dse_pkg::S_SORT_CMP: cmd.sort_step = 1'b1;
      dse_pkg::S_PUSH:     cmd.emit_init = 1'b1;
      // pop only while the stack holds something; empty means no subset left
      dse_pkg::S_POP:      cmd.pop = !stat.depth_zero;
      dse_pkg::S_SCAN_RD:  cmd.scan_rd = 1'b1;
      dse_pkg::S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) cmd.emit_init = 1'b1;
      end
      dse_pkg::S_EMIT_RD:  cmd.emit_rd = 1'b1;
      dse_pkg::S_EMIT: begin
        cmd.emit_out = 1'b1;
        if (stat.emit_last) cmd.count_inc = 1'b1;
      end
      dse_pkg::S_RESP: begin
        if (!stat.out_busy) begin
          cmd.resp = 1'b1;
          if (!stat.sorted) begin
            cmd.resp_status = dse_pkg::ST_OK;
            cmd.set_sorted  = 1'b1;
            cmd.count_inc   = 1'b1;
          end else begin
            cmd.resp_status = dse_pkg::ST_DONE;
            cmd.set_exhaust = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/dse_datapath.sv
// ----------------------------------------------------------------------------
// dse_datapath: storage and arithmetic of the distinct subset enumerator
// Value memory, index stack, sort and scan pointers, output register.
// ----------------------------------------------------------------------------
module dse_datapath #(
  parameter int MAX_ELEMENTS = dse_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = dse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  in_value,
  input  dse_pkg::cmd_t       cmd,
  output dse_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_ready,
  output dse_pkg::out_item_t  out_item
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [IW-1:0] stk [MAX_ELEMENTS];

  logic [CW-1:0] count, depth, outer, jj, p;
  logic [IW-1:0] ii;
  logic          sorted, exhausted;
  logic signed [VALUE_WIDTH-1:0] rd_a, rd_b, rd_e;
  logic [CW-1:0] top_next;

  // top of stack plus one: start index for a push
  always_comb begin
    if (depth == '0) top_next = '0;
    else top_next = CW'(stk[IW'(depth - 1'b1)]) + 1'b1;
  end

  assign stat.full       = (count >= CW'(MAX_ELEMENTS));
  assign stat.sorted     = sorted;
  assign stat.exhausted  = exhausted;
  assign stat.sort_done  = (outer >= count);
  assign stat.can_push   = (top_next < count) && (depth < CW'(MAX_ELEMENTS));
  assign stat.depth_zero = (depth == '0);
  assign stat.scan_end   = (jj >= count);
  assign stat.scan_hit   = (rd_a != rd_b);
  assign stat.emit_last  = (p + 1'b1 == depth);
  assign stat.out_busy   = out_valid && !out_ready;

  // memory read port: sort uses jj-1/jj, scan uses ii/jj
  always_ff @(posedge clk) begin
    if (cmd.sort_rd) begin
      rd_a <= mem[IW'(jj - 1'b1)];
      rd_b <= mem[IW'(jj)];
    end else if (cmd.scan_rd) begin
      rd_a <= mem[ii];
      rd_b <= mem[IW'(jj)];
    end
    if (cmd.emit_rd) rd_e <= mem[stk[IW'(p)]];
    if (cmd.load) mem[IW'(count)] <= VALUE_WIDTH'(in_value);
    else if (cmd.sort_step && jj != '0 && rd_b < rd_a) begin
      mem[IW'(jj - 1'b1)] <= rd_b;
      mem[IW'(jj)]        <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_start) stk[IW'(depth)] <= IW'(top_next);
    else if (cmd.scan_step && stat.scan_hit) stk[IW'(depth)] <= IW'(jj);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0; sorted <= 1'b0; exhausted <= 1'b0; depth <= '0;
      outer <= '0; jj <= '0; ii <= '0; p <= '0;
    end else begin
      if (cmd.load) count <= count + 1'b1;
      if (cmd.restart) begin
        sorted <= 1'b0; exhausted <= 1'b0; depth <= '0;
      end
      if (cmd.sort_init) begin
        outer <= CW'(1); jj <= CW'(1);
      end
      // insertion sort by adjacent swaps; jj walks down while a swap is made,
      // at zero or with no swap the compare step moves on to the next outer index
      if (cmd.sort_step) begin
        if (jj != '0 && rd_b < rd_a) jj <= jj - 1'b1;
        else begin
          outer <= outer + 1'b1; jj <= outer + 1'b1;
        end
      end
      if (cmd.set_sorted) begin
        sorted <= 1'b1; depth <= '0; exhausted <= 1'b0;
      end
      if (cmd.set_exhaust) begin
        exhausted <= 1'b1; depth <= '0;
      end
      if (cmd.push_start) depth <= depth + 1'b1;
      if (cmd.pop && depth != '0) begin
        ii    <= stk[IW'(depth - 1'b1)];
        jj    <= CW'(stk[IW'(depth - 1'b1)]) + 1'b1;
        depth <= depth - 1'b1;
      end
      if (cmd.scan_step) begin
        if (stat.scan_hit) depth <= depth + 1'b1;
        else jj <= jj + 1'b1;
      end
      if (cmd.emit_init) p <= '0;
      if (cmd.emit_out) p <= p + 1'b1;
    end
  end

  // subset counter
  logic [16:0] subset_counter;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.restart) subset_counter <= '0;
    else if (cmd.count_inc) subset_counter <= subset_counter + 1'b1;
  end

  // single responses carry the ordinal only for ok and no-more-subsets
  logic [16:0] resp_num;
  assign resp_num = (cmd.resp_status == dse_pkg::ST_OK ||
                     cmd.resp_status == dse_pkg::ST_DONE) ? subset_counter : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) out_valid <= 1'b0;
    else if (cmd.resp || cmd.emit_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_item <= '{element_value: '0, position_in_subset: '0, subset_size: '0,
                    subset_number: resp_num, last_of_run: 1'b1,
                    status: cmd.resp_status};
    end else if (cmd.emit_out) begin
      out_item.element_value      <= 32'(rd_e);
      out_item.position_in_subset <= 4'(p);
      out_item.subset_size        <= 5'(depth);
      out_item.subset_number      <= subset_counter;
      out_item.last_of_run        <= stat.emit_last;
      out_item.status             <= dse_pkg::ST_OK;
    end
  end

endmodule

FILE: hdl/distinct_subset_enumerator.sv
// ----------------------------------------------------------------------------
// distinct_subset_enumerator: distinct subsets of a loaded multiset
// ----------------------------------------------------------------------------
// Load values (mode 0) one per transaction; each load answers with one ack
// (or store-full) transaction. The first next request (mode 1) sorts the
// store in place by adjacent-swap insertion sort over the value memory,
// reading and then comparing each adjacent pair, then returns the empty
// subset. Each later next request advances the index stack to the following
// distinct subset in depth-first preorder and streams its elements, one per
// transaction with the last marked; each element is read and then emitted,
// and backtracking pops stack levels and scans indices, reading and then
// comparing each one. With many repeated values the scan can touch about
// N*N/2 indices in one request. A request after the last subset gives status
// "no more subsets". Mode 2 clears all. One input transaction is in service
// at a time.
module distinct_subset_enumerator #(
  parameter int MAX_ELEMENTS = dse_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = dse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dse_pkg::out_item_t  out_data
);

  dse_pkg::cmd_t  cmd;
  dse_pkg::stat_t stat;

  dse_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_mode(in_data.mode), .in_ready, .stat, .cmd
  );

  dse_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .in_value(in_data.value), .cmd, .stat,
    .out_valid, .out_ready, .out_item(out_data)
  );

endmodule

FILE: hdl/dse_checker.sv
// ----------------------------------------------------------------------------
// dse_checker: port-level assertions for the distinct subset enumerator
// Output hold, single-response shape and clear behavior, bound to the top.
// ----------------------------------------------------------------------------
module dse_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input dse_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input dse_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output dropped while stalled");

  a_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == dse_pkg::ST_ACK ||
                  out_data.status == dse_pkg::ST_FULL) |-> out_data.last_of_run)
    else $error("load response not last");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != dse_pkg::ST_OK |-> out_data.subset_size == 5'd0)
    else $error("error response carries a size");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == dse_pkg::MODE_CLEAR |=> !out_valid)
    else $error("output after clear");

endmodule

bind distinct_subset_enumerator dse_checker u_chk (.*);
